// ===== rtl/gsa_pkg.sv =====
// Shared types and constants for the generational slot allocator.
`default_nettype none
package gsa_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int GEN_BITS  = 16;
  localparam int IDX_BITS  = $clog2(NUM_SLOTS);

  localparam int IN_IDX_W  = 8;
  localparam int IN_GEN_W  = 16;
  localparam int TAG_W     = 32;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_GEN_W = 16;
  localparam int CMP_W     = (GEN_BITS > IN_GEN_W) ? GEN_BITS : IN_GEN_W;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [IN_IDX_W-1:0] slot_index;
    logic [IN_GEN_W-1:0] handle_generation;
    logic [TAG_W-1:0]    owner_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_IDX_W-1:0] granted_index;
    logic [OUT_GEN_W-1:0] granted_generation;
    logic                 handle_valid;
  } out_word_t;

  typedef struct packed {
    logic                found;
    logic [IDX_BITS-1:0] idx;
  } find_t;

endpackage
`default_nettype wire

// ===== rtl/gsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module gsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/gsa_find_free.sv =====
// Priority encoder that finds the lowest free slot in the occupancy vector.
`default_nettype none
module gsa_find_free (
  input  wire logic [gsa_pkg::NUM_SLOTS-1:0] occ,
  output gsa_pkg::find_t                     result
);
  import gsa_pkg::*;

  always_comb begin
    result.found = 1'b0;
    result.idx   = '0;
    // Scanning downward leaves the lowest free index as the final winner.
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        result.found = 1'b1;
        result.idx   = IDX_BITS'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/generational_slot_allocator.sv =====
// Top level of the generational slot allocator.
//
//   channel | direction | handshake        | word
//   in      | input     | in_valid/in_stall   | in_word  (cmd, slot_index, generation, tag)
//   out     | output    | out_valid/out_stall | out_word (status, index, generation, valid)
//
// Each word first reads the generation and owner RAMs as it is taken in S_IDLE,
// then forms the result and writes back in S_EXEC. The registered RAM read sets this.
// A new word is taken only in S_IDLE, so one word is finished before the next.
// Reset clears occupancy and generation-valid flops at once; no clearing pass.
// A stalled result holds the block in its write-back cycle until taken.
`default_nettype none
module generational_slot_allocator (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gsa_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gsa_pkg::out_word_t     out_word
);
  import gsa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_SLOTS-1:0] occ_r;
  logic [NUM_SLOTS-1:0] gen_vld_r;

  logic [1:0]          cmd_r;
  logic [IDX_BITS-1:0] addr_r;
  logic                in_range_r;
  logic                found_r;
  logic [IN_GEN_W-1:0] hgen_r;
  logic [TAG_W-1:0]    tag_r;

  logic      out_valid_r;
  out_word_t out_word_r;

  find_t               free_slot;
  logic                in_fire;
  logic                exec_fire;
  logic                in_range;
  logic [IDX_BITS-1:0] rd_addr;

  logic [GEN_BITS-1:0] gen_rdata;
  logic [GEN_BITS-1:0] gen_cur;
  logic [TAG_W-1:0]    own_rdata;
  logic                gen_we;
  logic                own_we;
  out_word_t           result;

  gsa_find_free u_find (
    .occ    (occ_r),
    .result (free_slot)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign in_range = ({1'b0, in_word.slot_index} < (IN_IDX_W + 1)'(NUM_SLOTS));
  assign rd_addr  = (in_word.cmd == CMD_ALLOC) ? free_slot.idx
                                                : in_word.slot_index[IDX_BITS-1:0];

  assign gen_cur = gen_vld_r[addr_r] ? gen_rdata : '0;
  assign gen_we  = exec_fire && (cmd_r == CMD_FREE) && in_range_r;
  assign own_we  = exec_fire && (cmd_r == CMD_ALLOC) && found_r;

  gsa_ram #(.WIDTH(GEN_BITS), .DEPTH(NUM_SLOTS)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (addr_r),
    .wdata (gen_cur + GEN_BITS'(1)),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (gen_rdata)
  );

  gsa_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SLOTS)) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (addr_r),
    .wdata (tag_r),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (own_rdata)
  );

  always_comb begin
    result = '0;
    unique case (cmd_r)
      CMD_ALLOC: begin
        if (found_r) begin
          result.status             = ST_DONE;
          result.granted_index      = OUT_IDX_W'(addr_r);
          result.granted_generation = OUT_GEN_W'(gen_cur);
        end else begin
          result.status = ST_FULL;
        end
      end
      CMD_FREE: begin
        result.status = in_range_r ? ST_DONE : ST_RANGE;
      end
      CMD_CHECK: begin
        if (in_range_r) begin
          result.status       = ST_DONE;
          result.handle_valid = occ_r[addr_r] &&
                                (CMP_W'(gen_cur) == CMP_W'(hgen_r)) &&
                                (own_rdata == tag_r);
        end else begin
          result.status = ST_RANGE;
        end
      end
      default: begin
        result.status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EXEC;
      S_EXEC:  if (exec_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      gen_vld_r   <= '0;
    end else begin
      state_r <= state_nxt;

      if (in_fire) begin
        cmd_r      <= in_word.cmd;
        addr_r     <= rd_addr;
        in_range_r <= in_range;
        found_r    <= free_slot.found;
        hgen_r     <= in_word.handle_generation;
        tag_r      <= in_word.owner_tag;
      end

      if (own_we) begin
        occ_r[addr_r] <= 1'b1;
      end
      if (gen_we) begin
        occ_r[addr_r]     <= 1'b0;
        gen_vld_r[addr_r] <= 1'b1;
      end

      if (exec_fire) begin
        out_valid_r <= 1'b1;
        out_word_r  <= result;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A granted slot must have been free when it was chosen.
  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r == CMD_ALLOC && found_r) |-> !occ_r[addr_r])
    else $error("allocate granted an occupied slot");

  // After a grant the slot is marked occupied.
  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    own_we |=> occ_r[addr_r])
    else $error("granted slot not marked occupied");

  // After a free the slot is released.
  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    gen_we |=> !occ_r[addr_r] && gen_vld_r[addr_r])
    else $error("freed slot still occupied");

  // A full report only happens when no slot is free.
  a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r == CMD_ALLOC && !found_r) |-> (&occ_r))
    else $error("table reported full with a free slot");

  // A result that raises out_valid comes from the write-back cycle just before it.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared outside the write-back cycle");

endmodule
`default_nettype wire
